/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/sphx_pkg.sv */
package sphx_pkg;

	localparam int MAX_JOINTS_DEF = 256;

	// Unsaturated rounded quaternion product component.
	localparam int QW = 21;
	// Translation difference in relative mode.
	localparam int VW = 33;
	// Rounded cross product term.
	localparam int TW = 38;
	// Multiply-accumulate register.
	localparam int ACCW = 60;
	// Squared norm, square root and divider widths.
	localparam int N2W = 42;
	localparam int LW = 21;
	localparam int DVW = 36;

	localparam logic signed [15:0] Q_ONE = 16'sd16384;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_SINGLE_ROOT = 1'b1;

	// Next value modulo three for a component index.
	function automatic logic [1:0] nxt3(input logic [1:0] c);
		logic [1:0] r;
		unique case (c)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat_q(input logic signed [ACCW-1:0] v);
		logic signed [15:0] r;
		if (v > 32767) begin
			r = 16'sh7fff;
		end else if (v < -32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat_p(input logic signed [ACCW-1:0] v);
		logic signed [31:0] r;
		if (v > ACCW'(64'sd2147483647)) begin
			r = 32'sh7fffffff;
		end else if (v < ACCW'(-64'sd2147483648)) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* hdl/sphx_in_if.sv */
interface sphx_in_if;
	logic valid;
	logic ready;
	logic signed [8:0] parent_index;
	logic signed [15:0] pose_w;
	logic signed [15:0] pose_x;
	logic signed [15:0] pose_y;
	logic signed [15:0] pose_z;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic last_joint;

	modport source (output valid, parent_index, pose_w, pose_x, pose_y, pose_z,
		pos_x, pos_y, pos_z, last_joint, input ready);
	modport sink (input valid, parent_index, pose_w, pose_x, pose_y, pose_z,
		pos_x, pos_y, pos_z, last_joint, output ready);
endinterface

/* hdl/sphx_out_if.sv */
interface sphx_out_if;
	logic valid;
	logic ready;
	logic [7:0] joint_index;
	logic signed [15:0] out_w;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic signed [15:0] out_z;
	logic signed [31:0] out_pos_x;
	logic signed [31:0] out_pos_y;
	logic signed [31:0] out_pos_z;
	logic out_last;
	logic bad_parent;

	modport source (output valid, joint_index, out_w, out_x, out_y, out_z,
		out_pos_x, out_pos_y, out_pos_z, out_last, bad_parent, input ready);
	modport sink (input valid, joint_index, out_w, out_x, out_y, out_z,
		out_pos_x, out_pos_y, out_pos_z, out_last, bad_parent, output ready);
endinterface

/* hdl/sphx_cfg_if.sv */
interface sphx_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/skeleton_pose_hierarchy_transform.sv */
// An accepted word reads the parent's stored transform, then runs the quaternion product,
// cross product and rotation sum; renormalizing the composed quaternion adds the squared
// norm, the square-root steps and a divide per component, or gives identity when its length
// is nearly zero. Pass-through joints skip the multiply phases. One joint at a time; one
// shared multiplier does 31 multiply-accumulates. The output register lets the next joint
// start while a result word waits. Reset (arst_n low, asynchronous) clears the joint counter,
// the configuration registers and all control state; the transform stores are not cleared.
`include "assert_macros.svh"

module skeleton_pose_hierarchy_transform #(
	parameter int MAX_JOINTS = sphx_pkg::MAX_JOINTS_DEF
) (
	input logic clk,
	input logic arst_n,
	sphx_in_if.sink joint_in,
	sphx_out_if.source joint_out,
	sphx_cfg_if.sink cfg
);
	localparam int AW = $clog2(MAX_JOINTS);
	localparam int CW = $clog2(MAX_JOINTS + 1);
	localparam int QW = sphx_pkg::QW;
	localparam int VW = sphx_pkg::VW;
	localparam int TW = sphx_pkg::TW;
	localparam int ACCW = sphx_pkg::ACCW;
	localparam int N2W = sphx_pkg::N2W;

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_MAC = 3'd3;
	localparam logic [2:0] S_NORM = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	// Multiply-accumulate phases: quaternion product, first cross product,
	// rotation sum, squared norm.
	localparam logic [1:0] PH_Q = 2'd0;
	localparam logic [1:0] PH_T = 2'd1;
	localparam logic [1:0] PH_R = 2'd2;
	localparam logic [1:0] PH_N = 2'd3;

	logic [2:0] state_q;
	logic [1:0] ph_q, comp_q;
	logic [2:0] term_q;
	logic [CW-1:0] cnt_q;
	logic mode_q, sr_q;

	logic [AW-1:0] addr_q;
	logic signed [15:0] qin_q [4];
	logic signed [31:0] tin_q [3];
	logic last_q, over_q, pass_q, bad_q;

	logic signed [QW-1:0] pq_q [4];
	logic signed [31:0] pt_q [3];
	logic signed [VW-1:0] v_q [3];
	logic signed [QW-1:0] oq_q [4];
	logic signed [TW-1:0] t_q [3];
	logic signed [31:0] ot_q [3];
	logic signed [ACCW-1:0] acc_q;

	// Absolute transform stores, one entry per joint.
	logic [63:0] rot_mem [MAX_JOINTS];
	logic [63:0] pxy_mem [MAX_JOINTS];
	logic [31:0] pz_mem [MAX_JOINTS];
	logic [63:0] rot_rd_q, pxy_rd_q;
	logic [31:0] pz_rd_q;

	logic out_valid_q;
	logic [7:0] jidx_q;
	logic signed [15:0] oqo_q [4];
	logic signed [31:0] opo_q [3];
	logic olast_q, obad_q;

	logic in_acc, fin_go, renorm, root0, par_ge, over, pass, bad;
	logic [1:0] c1, c2, ncomp_last;
	logic [2:0] nterms;
	logic term_done;
	logic signed [QW-1:0] a_op;
	logic signed [TW-1:0] b_op;
	logic mac_neg;
	logic signed [QW+TW-1:0] prod;
	logic signed [ACCW-1:0] rnd14, rnd13;
	logic norm_start, norm_done;
	logic signed [15:0] nq [4];
	logic signed [15:0] q_res [4], q_st [4];
	logic signed [31:0] p_res [3], p_st [3];

	assign in_acc = joint_in.valid && joint_in.ready;
	assign joint_in.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign renorm = !mode_q && sr_q;
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || joint_out.ready);

	// Joint classification at acceptance. The joint counter is the joint's index.
	assign over = cnt_q >= CW'(MAX_JOINTS);
	assign root0 = sr_q && (cnt_q == '0);
	assign par_ge = 32'(joint_in.parent_index[7:0]) >= 32'(cnt_q);
	assign pass = over || root0 || joint_in.parent_index[8] || par_ge;
	assign bad = over || (!root0 && !joint_in.parent_index[8] && par_ge);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			sr_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sphx_pkg::CFG_MODE: mode_q <= cfg.data;
				sphx_pkg::CFG_SINGLE_ROOT: sr_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier. Each phase walks its
	// components, and each component sums a few signed products.
	assign c1 = sphx_pkg::nxt3(comp_q);
	assign c2 = sphx_pkg::nxt3(c1);

	always_comb begin
		a_op = '0;
		b_op = '0;
		mac_neg = 1'b0;
		nterms = 3'd4;
		ncomp_last = 2'd3;
		unique case (ph_q)
			PH_Q: begin
				a_op = pq_q[term_q[1:0]];
				b_op = TW'(qin_q[comp_q ^ term_q[1:0]]);
				unique case (comp_q)
					2'd0: mac_neg = term_q[1:0] != 2'd0;
					2'd1: mac_neg = term_q[1:0] == 2'd3;
					2'd2: mac_neg = term_q[1:0] == 2'd1;
					default: mac_neg = term_q[1:0] == 2'd2;
				endcase
			end
			PH_T: begin
				nterms = 3'd2;
				ncomp_last = 2'd2;
				if (term_q == 3'd0) begin
					a_op = pq_q[c1 + 2'd1];
					b_op = TW'(v_q[c2]);
				end else begin
					a_op = pq_q[c2 + 2'd1];
					b_op = TW'(v_q[c1]);
					mac_neg = 1'b1;
				end
			end
			PH_R: begin
				nterms = 3'd3;
				ncomp_last = 2'd2;
				if (term_q == 3'd0) begin
					a_op = pq_q[0];
					b_op = t_q[comp_q];
				end else if (term_q == 3'd1) begin
					a_op = pq_q[c1 + 2'd1];
					b_op = t_q[c2];
				end else begin
					a_op = pq_q[c2 + 2'd1];
					b_op = t_q[c1];
					mac_neg = 1'b1;
				end
			end
			default: begin
				ncomp_last = 2'd0;
				a_op = oq_q[term_q[1:0]];
				b_op = TW'(oq_q[term_q[1:0]]);
			end
		endcase
	end

	assign prod = a_op * b_op;
	assign term_done = term_q == nterms;
	assign rnd14 = (acc_q + ACCW'(1 << 13)) >>> 14;
	assign rnd13 = (acc_q + ACCW'(1 << 12)) >>> 13;
	assign norm_start = (state_q == S_MAC) && (ph_q == PH_N) && term_done;

	sphx_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(norm_start),
		.n2(N2W'(acc_q)),
		.comp(oq_q),
		.done(norm_done),
		.q_out(nq)
	);

	// Final transform and what goes into the store: in absolute mode the
	// result itself, in relative mode the incoming absolute transform.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (pass_q) begin
				q_res[i] = qin_q[i];
			end else if (renorm) begin
				q_res[i] = nq[i];
			end else begin
				q_res[i] = sphx_pkg::sat_q(ACCW'(oq_q[i]));
			end
			q_st[i] = mode_q ? qin_q[i] : q_res[i];
		end
		for (int i = 0; i < 3; i++) begin
			p_res[i] = pass_q ? tin_q[i] : ot_q[i];
			p_st[i] = mode_q ? tin_q[i] : p_res[i];
		end
	end

	// Stores: registered read at the parent address, write at the joint index.
	always_ff @(posedge clk) begin
		rot_rd_q <= rot_mem[addr_q];
		pxy_rd_q <= pxy_mem[addr_q];
		pz_rd_q <= pz_mem[addr_q];
		if (fin_go && !over_q) begin
			rot_mem[cnt_q[AW-1:0]] <= {q_st[3], q_st[2], q_st[1], q_st[0]};
			pxy_mem[cnt_q[AW-1:0]] <= {p_st[1], p_st[0]};
			pz_mem[cnt_q[AW-1:0]] <= p_st[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q <= PH_Q;
			comp_q <= 2'd0;
			term_q <= 3'd0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (joint_out.valid && joint_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					state_q <= pass_q ? S_FIN : S_MAC;
					ph_q <= PH_Q;
					comp_q <= 2'd0;
					term_q <= 3'd0;
				end
				S_MAC: begin
					if (!term_done) begin
						term_q <= term_q + 3'd1;
					end else begin
						term_q <= 3'd0;
						if (comp_q == ncomp_last) begin
							comp_q <= 2'd0;
							unique case (ph_q)
								PH_Q: ph_q <= PH_T;
								PH_T: ph_q <= PH_R;
								PH_R: begin
									if (renorm) begin
										ph_q <= PH_N;
									end else begin
										state_q <= S_FIN;
									end
								end
								default: state_q <= S_NORM;
							endcase
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end
				end
				S_NORM: begin
					if (norm_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
						if (last_q) begin
							cnt_q <= '0;
						end else if (cnt_q < CW'(MAX_JOINTS)) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= AW'(joint_in.parent_index[7:0]);
			qin_q[0] <= joint_in.pose_w;
			qin_q[1] <= joint_in.pose_x;
			qin_q[2] <= joint_in.pose_y;
			qin_q[3] <= joint_in.pose_z;
			tin_q[0] <= joint_in.pos_x;
			tin_q[1] <= joint_in.pos_y;
			tin_q[2] <= joint_in.pos_z;
			last_q <= joint_in.last_joint;
			over_q <= over;
			pass_q <= pass;
			bad_q <= bad;
		end
		if (state_q == S_LOAD) begin
			// Relative mode works with the conjugate of the parent rotation
			// and with the translation measured from the parent.
			acc_q <= '0;
			pq_q[0] <= QW'($signed(rot_rd_q[15:0]));
			for (int i = 1; i < 4; i++) begin
				pq_q[i] <= mode_q ? -QW'($signed(rot_rd_q[16*i +: 16]))
					: QW'($signed(rot_rd_q[16*i +: 16]));
			end
			pt_q[0] <= pxy_rd_q[31:0];
			pt_q[1] <= pxy_rd_q[63:32];
			pt_q[2] <= pz_rd_q;
			v_q[0] <= mode_q ? VW'(tin_q[0]) - VW'($signed(pxy_rd_q[31:0])) : VW'(tin_q[0]);
			v_q[1] <= mode_q ? VW'(tin_q[1]) - VW'($signed(pxy_rd_q[63:32])) : VW'(tin_q[1]);
			v_q[2] <= mode_q ? VW'(tin_q[2]) - VW'($signed(pz_rd_q)) : VW'(tin_q[2]);
		end
		if (state_q == S_MAC) begin
			if (!term_done) begin
				acc_q <= mac_neg ? acc_q - ACCW'(prod) : acc_q + ACCW'(prod);
			end else begin
				acc_q <= '0;
				unique case (ph_q)
					PH_Q: oq_q[comp_q] <= QW'(rnd14);
					PH_T: t_q[comp_q] <= TW'(rnd13);
					PH_R: ot_q[comp_q] <= sphx_pkg::sat_p(ACCW'(v_q[comp_q]) + rnd14
						+ (mode_q ? ACCW'(0) : ACCW'(pt_q[comp_q])));
					default: ;
				endcase
			end
		end
		if (fin_go) begin
			jidx_q <= 8'(cnt_q);
			for (int i = 0; i < 4; i++) begin
				oqo_q[i] <= q_res[i];
			end
			for (int i = 0; i < 3; i++) begin
				opo_q[i] <= p_res[i];
			end
			olast_q <= last_q;
			obad_q <= bad_q;
		end
	end

	assign joint_out.valid = out_valid_q;
	assign joint_out.joint_index = jidx_q;
	assign joint_out.out_w = oqo_q[0];
	assign joint_out.out_x = oqo_q[1];
	assign joint_out.out_y = oqo_q[2];
	assign joint_out.out_z = oqo_q[3];
	assign joint_out.out_pos_x = opo_q[0];
	assign joint_out.out_pos_y = opo_q[1];
	assign joint_out.out_pos_z = opo_q[2];
	assign joint_out.out_last = olast_q;
	assign joint_out.bad_parent = obad_q;

	`ASSERT_NEXT(a_accept_reads, clk, arst_n, in_acc, state_q == S_READ)
	`ASSERT_IMPL(a_result_from_fin, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_FIN)
	`ASSERT_NEXT(a_count_step, clk, arst_n, fin_go && !last_q && (cnt_q < CW'(MAX_JOINTS)), cnt_q == $past(cnt_q) + CW'(1))
endmodule

/* hdl/sphx_norm.sv */
module sphx_norm (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [sphx_pkg::N2W-1:0] n2,
	input logic signed [sphx_pkg::QW-1:0] comp [4],
	output logic done,
	output logic signed [15:0] q_out [4]
);
	localparam int QW = sphx_pkg::QW;
	localparam int N2W = sphx_pkg::N2W;
	localparam int LW = sphx_pkg::LW;
	localparam int DVW = sphx_pkg::DVW;
	localparam int ACCW = sphx_pkg::ACCW;
	localparam int DCW = $clog2(DVW);

	localparam logic [1:0] N_IDLE = 2'd0;
	localparam logic [1:0] N_SQRT = 2'd1;
	localparam logic [1:0] N_PREP = 2'd2;
	localparam logic [1:0] N_DIV = 2'd3;

	logic [1:0] st_q;
	logic done_q;
	logic signed [QW-1:0] c_q [4];
	logic [N2W-1:0] n_q, r_q, b_q, rb, r_next;
	logic [LW-1:0] len_q;
	logic [1:0] ci_q;
	logic [LW:0] rem_q, rem_sh;
	logic [DVW-1:0] dvd_q, quo_q, quo_f;
	logic [DCW-1:0] dc_q;
	logic [QW-1:0] mag;
	logic q_bit;
	logic signed [ACCW-1:0] q_signed;

	assign rb = r_q + b_q;
	assign r_next = (n_q >= rb) ? ((r_q >> 1) + b_q) : (r_q >> 1);
	assign mag = c_q[ci_q][QW-1] ? QW'(-c_q[ci_q]) : QW'(c_q[ci_q]);
	assign rem_sh = {rem_q[LW-1:0], dvd_q[DVW-1]};
	assign q_bit = rem_sh >= {1'b0, len_q};
	assign quo_f = {quo_q[DVW-2:0], q_bit};
	assign q_signed = c_q[ci_q][QW-1] ? -$signed(ACCW'(quo_f)) : $signed(ACCW'(quo_f));
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				N_IDLE: begin
					if (start) begin
						if (n2 < N2W'(3)) begin
							done_q <= 1'b1;
						end else begin
							st_q <= N_SQRT;
						end
					end
				end
				N_SQRT: begin
					if (b_q[0]) begin
						st_q <= N_PREP;
					end
				end
				N_PREP: st_q <= N_DIV;
				N_DIV: begin
					if (dc_q == DCW'(DVW - 1)) begin
						if (ci_q == 2'd3) begin
							st_q <= N_IDLE;
							done_q <= 1'b1;
						end else begin
							st_q <= N_PREP;
						end
					end
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			N_IDLE: begin
				for (int i = 0; i < 4; i++) begin
					c_q[i] <= comp[i];
				end
				n_q <= n2;
				r_q <= '0;
				b_q <= N2W'(1) << (N2W - 2);
				ci_q <= 2'd0;
				if (start && n2 < N2W'(3)) begin
					q_out[0] <= sphx_pkg::Q_ONE;
					q_out[1] <= '0;
					q_out[2] <= '0;
					q_out[3] <= '0;
				end
			end
			N_SQRT: begin
				if (n_q >= rb) begin
					n_q <= n_q - rb;
				end
				r_q <= r_next;
				b_q <= b_q >> 2;
				if (b_q[0]) begin
					len_q <= LW'(r_next);
				end
			end
			N_PREP: begin
				dvd_q <= (DVW'(mag) << 14) + DVW'(len_q >> 1);
				rem_q <= '0;
				quo_q <= '0;
				dc_q <= '0;
			end
			N_DIV: begin
				rem_q <= q_bit ? (rem_sh - {1'b0, len_q}) : rem_sh;
				quo_q <= quo_f;
				dvd_q <= dvd_q << 1;
				dc_q <= dc_q + DCW'(1);
				if (dc_q == DCW'(DVW - 1)) begin
					q_out[ci_q] <= sphx_pkg::sat_q(q_signed);
					ci_q <= ci_q + 2'd1;
				end
			end
			default: ;
		endcase
	end
endmodule

/* tb/skeleton_pose_hierarchy_transform_test.sv */
`timescale 1ns / 100ps

module skeleton_pose_hierarchy_transform_test;

	// One result word as the block should produce it.
	typedef struct {
		logic [7:0] idx;
		logic signed [15:0] w, x, y, z;
		logic signed [31:0] px, py, pz;
		logic last, bad;
	} joint_result_t;

	// Forward kinematics predictor: tracks the joint counter, the registers and the
	// absolute transform of every joint, and queues the result each accepted joint causes.
	class fk_scoreboard;
		localparam int MAXJ = sphx_pkg::MAX_JOINTS_DEF;
		longint abs_rot[MAXJ][4];
		longint abs_pos[MAXJ][3];
		int joint_cnt;
		bit mode_rel, single_root;
		joint_result_t expected_q[$];
		int failures;

		function new();
			joint_cnt = 0;
			mode_rel = 0;
			single_root = 0;
			failures = 0;
		endfunction

		function void set_reg(logic index, logic data);
			if (index == sphx_pkg::CFG_MODE) begin
				mode_rel = data;
			end else begin
				single_root = data;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Round half up by s bits; the arithmetic shift floors.
		function longint rnd(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint sat(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void qmul(input longint a[4], input longint b[4], output longint r[4]);
			r[0] = rnd(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3], 14);
			r[1] = rnd(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2], 14);
			r[2] = rnd(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1], 14);
			r[3] = rnd(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0], 14);
		endfunction

		function void qrot(input longint q[4], input longint v[3], output longint r[3]);
			longint t[3];
			t[0] = rnd(q[2]*v[2] - q[3]*v[1], 13);
			t[1] = rnd(q[3]*v[0] - q[1]*v[2], 13);
			t[2] = rnd(q[1]*v[1] - q[2]*v[0], 13);
			r[0] = v[0] + rnd(q[0]*t[0] + q[2]*t[2] - q[3]*t[1], 14);
			r[1] = v[1] + rnd(q[0]*t[1] + q[3]*t[0] - q[1]*t[2], 14);
			r[2] = v[2] + rnd(q[0]*t[2] + q[1]*t[1] - q[2]*t[0], 14);
		endfunction

		function longint unsigned isqrt(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// Renormalize to unit length, or fall back to identity when nearly zero.
		function void qnorm(inout longint q[4]);
			longint unsigned n2, len, mag;
			n2 = 0;
			for (int i = 0; i < 4; i++) n2 += longint'(q[i] * q[i]);
			if (n2 < 3) begin
				q[0] = 16384; q[1] = 0; q[2] = 0; q[3] = 0;
			end else begin
				len = isqrt(n2);
				for (int i = 0; i < 4; i++) begin
					mag = (q[i] < 0 ? -q[i] : q[i]) * 16384;
					mag = (mag + len / 2) / len;
					q[i] = q[i] < 0 ? -longint'(mag) : longint'(mag);
				end
			end
		endfunction

		function void note(int parent, longint qi[4], longint ti[3], bit last);
			longint pq[4], pt[3], oq[4], ot[3], tmp[3];
			bit over, bad, pass;
			joint_result_t e;
			over = joint_cnt >= MAXJ;
			bad = 0;
			pass = 1;
			if (over) bad = 1;
			else if (single_root && joint_cnt == 0) pass = 1;
			else if (parent < 0) pass = 1;
			else if (parent >= joint_cnt) bad = 1;
			else pass = 0;
			oq = qi;
			ot = ti;
			if (!pass) begin
				pq = abs_rot[parent];
				pt = abs_pos[parent];
				if (!mode_rel) begin
					qmul(pq, qi, oq);
					if (single_root) qnorm(oq);
					qrot(pq, ti, ot);
					for (int i = 0; i < 3; i++) ot[i] += pt[i];
				end else begin
					for (int i = 1; i < 4; i++) pq[i] = -pq[i];
					qmul(pq, qi, oq);
					for (int i = 0; i < 3; i++) tmp[i] = ti[i] - pt[i];
					qrot(pq, tmp, ot);
				end
				for (int i = 0; i < 4; i++) oq[i] = sat(oq[i], -32768, 32767);
				for (int i = 0; i < 3; i++) ot[i] = sat(ot[i], -64'sd2147483648, 64'sd2147483647);
			end
			// Absolute mode keeps the composed result, relative mode keeps the input.
			if (!over) begin
				if (mode_rel) begin
					abs_rot[joint_cnt] = qi;
					abs_pos[joint_cnt] = ti;
				end else begin
					abs_rot[joint_cnt] = oq;
					abs_pos[joint_cnt] = ot;
				end
			end
			e.idx = joint_cnt[7:0];
			e.w = 16'(oq[0]); e.x = 16'(oq[1]); e.y = 16'(oq[2]); e.z = 16'(oq[3]);
			e.px = 32'(ot[0]); e.py = 32'(ot[1]); e.pz = 32'(ot[2]);
			e.last = last;
			e.bad = bad;
			expected_q.push_back(e);
			if (last) joint_cnt = 0;
			else if (joint_cnt < MAXJ) joint_cnt++;
		endfunction

		function void cmp(string field, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", field, exp_v, act_v);
				failures++;
			end
		endfunction

		function void check(joint_result_t a);
			joint_result_t e;
			if (expected_q.size() == 0) begin
				$error("result word for joint %0d arrived with nothing expected", a.idx);
				failures++;
			end else begin
				e = expected_q.pop_front();
				cmp("joint_index", e.idx, a.idx);
				cmp("out_w", e.w, a.w);
				cmp("out_x", e.x, a.x);
				cmp("out_y", e.y, a.y);
				cmp("out_z", e.z, a.z);
				cmp("out_pos_x", e.px, a.px);
				cmp("out_pos_y", e.py, a.py);
				cmp("out_pos_z", e.pz, a.pz);
				cmp("out_last", e.last, a.last);
				cmp("bad_parent", e.bad, a.bad);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sphx_in_if jin();
	sphx_out_if jout();
	sphx_cfg_if cfgc();

	skeleton_pose_hierarchy_transform dut (
		.clk(clk),
		.arst_n(arst_n),
		.joint_in(jin),
		.joint_out(jout),
		.cfg(cfgc)
	);

	fk_scoreboard sb = new();

	// Percent of cycles in which the sender or the receiver idles.
	int tx_idle;
	int rx_idle;
	// A request for one long receiver stall; the receiver process clears it.
	bit hold_req;
	int hold_left;
	// The generator's own copy of the joint counter, used to pick legal parents.
	int gen_idx;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#20ms;
		$display("skeleton_pose_hierarchy_transform_test: FAIL");
		$finish;
	end

	// Monitor: every handshake is sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		joint_result_t r;
		if (jin.valid && jin.ready) begin
			sb.note(jin.parent_index,
				'{longint'(jin.pose_w), longint'(jin.pose_x),
				longint'(jin.pose_y), longint'(jin.pose_z)},
				'{longint'(jin.pos_x), longint'(jin.pos_y), longint'(jin.pos_z)},
				jin.last_joint);
		end
		if (cfgc.valid && cfgc.ready) begin
			sb.set_reg(cfgc.index, cfgc.data);
		end
		if (jout.valid && jout.ready) begin
			r.idx = jout.joint_index;
			r.w = jout.out_w; r.x = jout.out_x; r.y = jout.out_y; r.z = jout.out_z;
			r.px = jout.out_pos_x; r.py = jout.out_pos_y; r.pz = jout.out_pos_z;
			r.last = jout.out_last;
			r.bad = jout.bad_parent;
			sb.check(r);
		end
	end

	// Receiver: random back-pressure, plus one long stall on request so the block fills.
	initial begin
		jout.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				jout.ready <= 1'b0;
			end else begin
				jout.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	// Offer one joint word and hold it until the block takes it.
	task automatic send_joint(int parent, int w, int x, int y, int z,
		int px, int py, int pz, bit last);
		while ($urandom_range(99) < tx_idle) begin
			jin.valid <= 1'b0;
			@(negedge clk);
		end
		jin.parent_index <= parent[8:0];
		jin.pose_w <= w[15:0];
		jin.pose_x <= x[15:0];
		jin.pose_y <= y[15:0];
		jin.pose_z <= z[15:0];
		jin.pos_x <= px;
		jin.pos_y <= py;
		jin.pos_z <= pz;
		jin.last_joint <= last;
		jin.valid <= 1'b1;
		do @(posedge clk); while (!(jin.ready === 1'b1));
		@(negedge clk);
		if (last) gen_idx = 0;
		else if (gen_idx < sphx_pkg::MAX_JOINTS_DEF) gen_idx++;
	endtask

	// Registers change only once the block has drained, with time for a slow joint.
	task automatic wait_drained();
		jin.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// Offer one register write and return at the falling edge after it is taken;
	// the caller drops valid once its writes are done.
	task automatic write_reg(logic index, logic data);
		cfgc.index <= index;
		cfgc.data <= data;
		cfgc.valid <= 1'b1;
		do @(posedge clk); while (!(cfgc.ready === 1'b1));
		@(negedge clk);
	endtask

	task automatic set_config(bit rel, bit sr);
		wait_drained();
		write_reg(sphx_pkg::CFG_MODE, rel);
		write_reg(sphx_pkg::CFG_SINGLE_ROOT, sr);
		cfgc.valid <= 1'b0;
	endtask

	// One random joint: mostly a legal parent, some roots, some parents that are not
	// below the joint. Quaternions are full range, near unit or nearly zero.
	task automatic rand_joint(bit last);
		int parent, kind, w, x, y, z, px, py, pz;
		kind = $urandom_range(99);
		if (kind < 75 && gen_idx > 0) parent = $urandom_range(gen_idx - 1);
		else if (kind < 88) parent = -1;
		else parent = $urandom_range(gen_idx < 255 ? gen_idx : 255, 255);
		kind = $urandom_range(9);
		if (kind < 4) begin
			w = $urandom; x = $urandom; y = $urandom; z = $urandom;
		end else if (kind < 8) begin
			w = $urandom_range(16384, 9000);
			x = $urandom_range(8000) - 4000;
			y = $urandom_range(8000) - 4000;
			z = $urandom_range(8000) - 4000;
		end else begin
			w = $urandom_range(2) - 1; x = $urandom_range(2) - 1;
			y = $urandom_range(2) - 1; z = $urandom_range(2) - 1;
		end
		if ($urandom_range(3) == 0) begin
			px = $urandom; py = $urandom; pz = $urandom;
		end else begin
			px = $urandom_range(2097152) - 1048576;
			py = $urandom_range(2097152) - 1048576;
			pz = $urandom_range(2097152) - 1048576;
		end
		send_joint(parent, w, x, y, z, px, py, pz, last);
	endtask

	// Short skeletons of random length, each closed by a joint marked last.
	task automatic rand_skeletons(int count);
		int left;
		left = 0;
		for (int n = 0; n < count; n++) begin
			if (left == 0) left = $urandom_range(12, 1);
			rand_joint(left == 1 || n == count - 1);
			left--;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		hold_req = 1'b0;
		gen_idx = 0;
		tx_idle = 0;
		rx_idle = 0;
		jin.valid = 1'b0;
		jin.parent_index = '0;
		jin.pose_w = '0; jin.pose_x = '0; jin.pose_y = '0; jin.pose_z = '0;
		jin.pos_x = '0; jin.pos_y = '0; jin.pos_z = '0;
		jin.last_joint = 1'b0;
		cfgc.valid = 1'b0;
		cfgc.index = sphx_pkg::CFG_MODE;
		cfgc.data = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: absolute mode, two roots.
		set_config(1'b0, 1'b0);
		send_joint(-1, sphx_pkg::Q_ONE, 0, 0, 0, 0, 0, 0, 1'b0);
		// Extreme quaternion and translations drive both saturations.
		send_joint(0, 32767, -32768, 32767, -32768,
			32'h7fffffff, 32'h80000000, 12345, 1'b0);
		send_joint(1, -32768, 32767, -32768, 32767,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0);
		// A parent equal to the joint, and the highest parent index, are both bad.
		send_joint(3, 10000, 0, 0, 0, 5, 6, 7, 1'b0);
		send_joint(255, 0, 10000, 0, 0, 5, 6, 7, 1'b0);
		send_joint(2, 11585, 11585, 0, 0, 65536, -65536, 1, 1'b0);
		send_joint(-1, -32768, -32768, -32768, -32768,
			32'h80000000, 32'h80000000, 32'h80000000, 1'b1);

		// Single root: joint zero ignores its parent, children are renormalized,
		// and a nearly zero product falls back to identity.
		set_config(1'b0, 1'b1);
		send_joint(200, sphx_pkg::Q_ONE, 0, 0, 0, 100, 200, 300, 1'b0);
		send_joint(0, 1, 0, 0, 0, 1, 2, 3, 1'b0);
		send_joint(1, 10000, 5000, -3000, 2000, -70000, 80000, 90000, 1'b0);
		send_joint(-1, 20000, 20000, 20000, 20000, 0, 0, 0, 1'b1);

		// Relative mode, with and without a single root.
		set_config(1'b1, 1'b0);
		send_joint(-1, 11585, 0, 11585, 0, 1000, 2000, 3000, 1'b0);
		send_joint(0, sphx_pkg::Q_ONE, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0, 1'b0);
		send_joint(1, 8192, 8192, 8192, 8192, -5, 5, -5, 1'b1);
		set_config(1'b1, 1'b1);
		send_joint(7, 9000, -9000, 9000, -9000, 4, 4, 4, 1'b0);
		send_joint(0, 9000, 9000, -9000, 9000, 32'h80000000, 1, 2, 1'b1);

		// Random: three idling profiles, each across all four register settings.
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = ph == 0 ? 33 : (ph == 1 ? 50 : 0);
			rx_idle = ph == 0 ? 50 : (ph == 1 ? 33 : 0);
			for (int c = 0; c < 4; c++) begin
				set_config(c[1], c[0]);
				if (ph == 0 && c == 0) hold_req = 1'b1;
				rand_skeletons(27);
				// One skeleton longer than the joint store overflows the counter.
				if (ph == 2 && c == 0) begin
					for (int n = 0; n < 262; n++) rand_joint(n == 261);
				end
			end
		end

		wait_drained();
		if (sb.failures == 0) begin
			$display("skeleton_pose_hierarchy_transform_test: PASS");
		end else begin
			$display("skeleton_pose_hierarchy_transform_test: FAIL");
		end
		$finish;
	end

endmodule
